// ----- hdl/pct_pkg.sv -----
// ---------------------------------------------------------------------------
// Palette color table package
// Shared widths, codes, item and table write types for the palette table.
// ---------------------------------------------------------------------------
package pct_pkg;

   // Number of color table entries. The table index is the low address bits.
   localparam int TABLE_ENTRIES = 512;
   localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);

   localparam int ADDR_W  = 9;
   localparam int ENTRY_W = 9;
   localparam int LEVEL_W = 3;
   localparam int BYTE_W  = 8;

   typedef logic [1:0]         func_type;
   typedef logic [2:0]         offset_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [ENTRY_W-1:0] entry_type;
   typedef logic [TABLE_AW-1:0] slot_type;
   typedef logic [LEVEL_W-1:0] level_type;

   // Function codes; any other code is flagged as bad and reads zero levels.
   localparam func_type FUNC_WRITE  = 2'd0;
   localparam func_type FUNC_LOOKUP = 2'd1;

   // Register offsets.
   localparam offset_type OFF_CONTROL = 3'd0;
   localparam offset_type OFF_ADDR_LO = 3'd2;
   localparam offset_type OFF_ADDR_HI = 3'd3;
   localparam offset_type OFF_DATA_LO = 3'd4;
   localparam offset_type OFF_DATA_HI = 3'd5;

   localparam slot_type LAST_SLOT = slot_type'(TABLE_ENTRIES - 1);

   typedef struct packed {
      func_type          func;
      offset_type        reg_offset;
      logic [BYTE_W-1:0] write_byte;
      logic              sprite_select;
      logic [3:0]        palette_index;
      logic [3:0]        color_index;
   } item_type;

   typedef struct packed {
      logic      en;
      slot_type  slot;
      entry_type data;
   } tbl_wr_type;

   function automatic slot_type table_slot(input addr_type addr);
      return slot_type'(addr);
   endfunction

endpackage

// ----- hdl/pct_ifs.sv -----
// ---------------------------------------------------------------------------
// Palette color table channels
// Valid/ready channels for request words and response words.
// ---------------------------------------------------------------------------
interface pct_req_if import pct_pkg::*; ();
   logic              valid;
   logic              ready;
   func_type          func;
   offset_type        reg_offset;
   logic [BYTE_W-1:0] write_byte;
   logic              sprite_select;
   logic [3:0]        palette_index;
   logic [3:0]        color_index;

   modport source (output valid, func, reg_offset, write_byte, sprite_select,
                   palette_index, color_index, input ready);
   modport sink   (input valid, func, reg_offset, write_byte, sprite_select,
                   palette_index, color_index, output ready);
endinterface

interface pct_rsp_if import pct_pkg::*; ();
   logic      valid;
   logic      ready;
   level_type red;
   level_type green;
   level_type blue;
   logic      bad_offset;

   modport source (output valid, red, green, blue, bad_offset, input ready);
   modport sink   (input valid, red, green, blue, bad_offset, output ready);
endinterface

// ----- hdl/pct_regs.sv -----
// ---------------------------------------------------------------------------
// Palette color table register block
// Decodes register writes, holds the table address and data latch, and
// issues table stores.
// ---------------------------------------------------------------------------
module pct_regs import pct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   output tbl_wr_type wr,
   output logic       bad
);

   addr_type  addr_ff, addr_in;
   entry_type latch_ff, latch_in;

   // The control byte steers nothing visible at the table outputs, so a write
   // to it is accepted without being stored.
   always_comb begin
      addr_in  = addr_ff;
      latch_in = latch_ff;
      bad      = 1'b0;
      wr.en    = 1'b0;
      wr.slot  = table_slot(addr_ff);
      wr.data  = {item.write_byte[0], latch_ff[BYTE_W-1:0]};
      if (item.func == FUNC_WRITE) begin
         unique case (item.reg_offset)
            OFF_CONTROL: begin
            end
            OFF_ADDR_LO: addr_in = {addr_ff[ADDR_W-1], item.write_byte};
            OFF_ADDR_HI: addr_in = {item.write_byte[0], addr_ff[BYTE_W-1:0]};
            OFF_DATA_LO: latch_in = {latch_ff[ENTRY_W-1], item.write_byte};
            OFF_DATA_HI: begin
               latch_in = wr.data;
               wr.en    = step;
               addr_in  = addr_ff + addr_type'(1);
            end
            default: bad = 1'b1;
         endcase
      end else if (item.func != FUNC_LOOKUP) begin
         bad = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         latch_ff <= '0;
      end else if (step) begin
         addr_ff  <= addr_in;
         latch_ff <= latch_in;
      end
   end

`ifndef SYNTH
   // A table store always advances the address by one.
   a_addr_advance: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> addr_ff == $past(addr_ff) + addr_type'(1))
      else $error("table address did not advance after a store");
`endif

endmodule

// ----- hdl/pct_table.sv -----
// ---------------------------------------------------------------------------
// Palette color table memory
// Single write, single read table with registered read data and a clearing
// sweep after reset.
// ---------------------------------------------------------------------------
module pct_table import pct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  tbl_wr_type wr,
   input  logic       rd_en,
   input  logic       rd_lookup,
   input  slot_type   rd_slot,
   output entry_type  rd_data,
   output logic       busy
);

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_ff;
   logic      clr_active_ff, clr_active_in;
   slot_type  clr_slot_ff, clr_slot_in;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_slot_in   = clr_slot_ff;
      if (clr_active_ff) begin
         clr_slot_in = clr_slot_ff + slot_type'(1);
         if (clr_slot_ff == LAST_SLOT) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_slot_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_slot_ff   <= clr_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_slot_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.slot] <= wr.data;
      end
   end

   // Words other than lookups load zero so the levels read as zero.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_lookup) begin
            rd_ff <= mem[rd_slot];
         end else begin
            rd_ff <= '0;
         end
      end
   end

   assign rd_data = rd_ff;
   assign busy    = clr_active_ff;

`ifndef SYNTH
   a_no_access_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !rd_en && !wr.en)
      else $error("table accessed during clearing sweep");

   a_clear_full_sweep: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_active_ff) |-> $past(clr_slot_ff) == LAST_SLOT)
      else $error("clearing sweep ended early");
`endif

endmodule

// ----- hdl/palette_color_table.sv -----
// ---------------------------------------------------------------------------
// Palette color table
// Register-programmed 512 x 9 color palette with a color lookup path.
// ---------------------------------------------------------------------------
// One request word is accepted per clock while the response side is ready; the
// word waits in the s1 register and its response in the table read register,
// with the rate set by the single read and write ports, each used at most once
// per word. After reset the block clears all TABLE_ENTRIES (512 as built)
// entries, one per cycle, and holds req ready low until that sweep is done.
// A write to offset 5 stores the latched color, visible to the next word.
module palette_color_table import pct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pct_req_if.sink    req_chan,
   pct_rsp_if.source  rsp_chan
);

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       bad_ff;
   logic       step;
   logic       busy;
   logic       accept;
   logic       bad;
   tbl_wr_type wr;
   entry_type  rd_data;

   assign step   = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !busy && (!s1_valid_ff || step);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.func          <= req_chan.func;
         s1_item_ff.reg_offset    <= req_chan.reg_offset;
         s1_item_ff.write_byte    <= req_chan.write_byte;
         s1_item_ff.sprite_select <= req_chan.sprite_select;
         s1_item_ff.palette_index <= req_chan.palette_index;
         s1_item_ff.color_index   <= req_chan.color_index;
      end
      if (step) begin
         bad_ff <= bad;
      end
   end

   pct_regs u_regs (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (s1_item_ff),
      .wr    (wr),
      .bad   (bad)
   );

   pct_table u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .rd_en     (step),
      .rd_lookup (s1_item_ff.func == FUNC_LOOKUP),
      .rd_slot   (table_slot({s1_item_ff.sprite_select, s1_item_ff.palette_index,
                              s1_item_ff.color_index})),
      .rd_data   (rd_data),
      .busy      (busy)
   );

   // Entry layout: blue in the low bits, red in the middle, green on top.
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.blue       = rd_data[LEVEL_W-1:0];
   assign rsp_chan.red        = rd_data[2*LEVEL_W-1:LEVEL_W];
   assign rsp_chan.green      = rd_data[3*LEVEL_W-1:2*LEVEL_W];
   assign rsp_chan.bad_offset = bad_ff;

`ifndef SYNTH
   a_non_lookup_zero: assert property (@(posedge clock) disable iff (reset)
      step && s1_item_ff.func != FUNC_LOOKUP |=>
         rsp_chan.red == '0 && rsp_chan.green == '0 && rsp_chan.blue == '0)
      else $error("non-lookup word returned nonzero color levels");
`endif

endmodule
